### rtl/ovff_pkg.sv
`timescale 1ns / 1ps

package ovff_pkg;

  localparam int unsigned MIC_CHANNELS = 4;

  localparam logic [47:0]        EMAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [48:0] XMAX  = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] XMIN  = -XMAX;
  localparam logic [26:0]        HALF_LN2_Q28 = 27'd93032640;
  localparam logic [63:0]        RND_HALF     = 64'h0000_0200_0000_0000;
  localparam logic [31:0]        QMAX    = 32'h7FFF_FFFF;
  localparam logic [31:0]        ONE_Q16 = 32'h0001_0000;

  localparam logic [2:0] FEAT_OWN   = 3'd0;
  localparam logic [2:0] FEAT_LVL0  = 3'd1;
  localparam logic [2:0] FEAT_CORR0 = 3'd4;
  localparam logic [2:0] FEAT_LAST  = 3'd6;
  localparam logic [1:0] CH_LAST    = 2'd3;
  localparam logic [1:0] J_LAST     = 2'd2;
  localparam logic [5:0] EXP_TOP    = 6'd48;
  localparam logic [5:0] EXP_KEEP   = 6'd29;
  localparam logic [4:0] LOG_LAST   = 5'd29;
  localparam logic [6:0] DIV_LAST   = 7'd95;
  localparam logic [4:0] SQRT_LAST  = 5'd31;

  typedef struct packed {
    logic signed [15:0] voice_ref;
    logic signed [15:0] mic_0;
    logic signed [15:0] mic_1;
    logic signed [15:0] mic_2;
    logic signed [15:0] mic_3;
    logic               sample_bad;
    logic               last_frame;
    logic [63:0]        seq_tag;
    logic [63:0]        time_ns;
  } item_t;

  typedef struct packed {
    logic [2:0]         feature_index;
    logic signed [31:0] feature_value;
    logic [63:0]        seq_out;
    logic [63:0]        time_out;
    logic               obs_valid;
    logic               last_feature;
  } result_t;

  typedef struct packed {
    logic [47:0]       own;
    logic [3:0][47:0]  che;
    logic [3:0][47:0]  crs;
    logic              bad;
    logic [1:0]        ref_mic;
    logic [63:0]       seq;
    logic [63:0]       tstamp;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_STEP,
    F_HAND
  } front_state_e;

  typedef enum logic [4:0] {
    B_IDLE,
    B_SUM,
    B_OWN_CHK,
    B_OWN_DIV,
    B_OWN_SQRT,
    B_LOAD,
    B_NORM,
    B_LOG,
    B_LVL,
    B_LVL_MUL,
    B_LVL_RND,
    B_CORR,
    B_CORR_MUL,
    B_CORR_CMP,
    B_CORR_DIV,
    B_CORR_SQRT,
    B_EMIT
  } back_state_e;

endpackage

### rtl/ovff_fifo.sv
`timescale 1ns / 1ps

module ovff_fifo #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= din_i;
  end

endmodule

### rtl/ovff_front.sv
`timescale 1ns / 1ps

module ovff_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  input  logic           push_i,
  output logic           full_o,
  input  ovff_pkg::item_t item_i,
  input  logic           job_full_i,
  output logic           job_push_o,
  output ovff_pkg::job_t job_o
);

  import ovff_pkg::*;

  front_state_e state_q, state_d;
  logic [1:0]   ch_q, refm_q, refcfg_q;
  item_t        itm_q;
  logic [47:0]  own_q;
  logic [3:0][47:0] che_q, crs_q;
  logic         bad_q;

  logic signed [15:0] s_ch, s_ref;
  logic signed [31:0] p_ch, p_x, p_own;

  function automatic logic signed [15:0] mic_sel(item_t it, logic [1:0] k);
    logic signed [15:0] s;
    unique case (k)
      2'd0:    s = it.mic_0;
      2'd1:    s = it.mic_1;
      2'd2:    s = it.mic_2;
      default: s = it.mic_3;
    endcase
    return s;
  endfunction

  function automatic logic [47:0] add_e(logic [47:0] a, logic [31:0] e);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, e};
    return s[48] ? EMAX : s[47:0];
  endfunction

  function automatic logic [47:0] add_x(logic [47:0] a, logic [31:0] p);
    logic signed [48:0] s;
    logic [47:0] r;
    s = $signed({a[47], a}) + $signed({{17{p[31]}}, p});
    if (s > XMAX)      r = XMAX[47:0];
    else if (s < XMIN) r = XMIN[47:0];
    else               r = s[47:0];
    return r;
  endfunction

  assign s_ch  = mic_sel(itm_q, ch_q);
  assign s_ref = mic_sel(itm_q, refm_q);
  assign p_ch  = s_ch * s_ch;
  assign p_x   = s_ch * s_ref;
  assign p_own = itm_q.voice_ref * itm_q.voice_ref;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (push_i) state_d = F_STEP;
      F_STEP: if (ch_q == CH_LAST) state_d = F_HAND;
      F_HAND: if (!itm_q.last_frame || !job_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o     = (state_q != F_IDLE);
    job_push_o = (state_q == F_HAND) && itm_q.last_frame && !job_full_i;
  end

  assign job_o.own     = own_q;
  assign job_o.che     = che_q;
  assign job_o.crs     = crs_q;
  assign job_o.bad     = bad_q;
  assign job_o.ref_mic = refm_q;
  assign job_o.seq     = itm_q.seq_tag;
  assign job_o.tstamp  = itm_q.time_ns;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      ch_q     <= 2'd0;
      refm_q   <= 2'd0;
      refcfg_q <= 2'd0;
      own_q    <= '0;
      che_q    <= '0;
      crs_q    <= '0;
      bad_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) refcfg_q <= cfg_wdata_i;
      unique case (state_q)
        F_IDLE: begin
          ch_q   <= 2'd0;
          refm_q <= refcfg_q;
        end
        F_STEP: begin
          che_q[ch_q] <= add_e(che_q[ch_q], p_ch);
          crs_q[ch_q] <= add_x(crs_q[ch_q], p_x);
          if (ch_q == 2'd0) begin
            own_q <= add_e(own_q, p_own);
            bad_q <= bad_q | itm_q.sample_bad;
          end
          ch_q <= ch_q + 2'd1;
        end
        F_HAND: begin
          // frame handed to the back end, start a fresh frame
          if (job_push_o) begin
            own_q <= '0;
            che_q <= '0;
            crs_q <= '0;
            bad_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) itm_q <= item_i;
  end

endmodule

### rtl/ovff_div.sv
`timescale 1ns / 1ps

module ovff_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [95:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  import ovff_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [95:0] num_q;
  logic [63:0] den_q, quo_q;
  logic [64:0] rem_q, rem_sh, rem_sub;
  logic        take;

  // one quotient bit per cycle, restoring
  assign rem_sh  = {rem_q[63:0], num_q[95]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = (rem_sh >= {1'b0, den_q});
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == DIV_LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[94:0], 1'b0};
      rem_q <= take ? rem_sub : rem_sh;
      quo_q <= {quo_q[62:0], take};
    end
  end

endmodule

### rtl/ovff_sqrt.sv
`timescale 1ns / 1ps

module ovff_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  import ovff_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [35:0] rem_q, rem_sh, trial;
  logic [31:0] root_q;
  logic        take;

  // two radicand bits per cycle
  assign rem_sh = {rem_q[33:0], x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= busy_q && (cnt_q == SQRT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == SQRT_LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[30:0], take};
    end
  end

endmodule

### rtl/ovff_back.sv
`timescale 1ns / 1ps

module ovff_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  ovff_pkg::job_t    job_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output ovff_pkg::result_t res_o
);

  import ovff_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [47:0] eref_q;
  logic [2:0]  feat_q;
  logic [31:0] val_q;
  logic [1:0]  idx_q, j_q;
  logic [4:0]  it_q;
  logic [48:0] v_q;
  logic [5:0]  e_q;
  logic [31:0] m_q;
  logic [29:0] frac_q;
  logic [3:0][35:0] lg_q;
  logic [3:0][5:0]  ex_q;
  logic [35:0] lg_ref_q;
  logic [5:0]  ex_ref_q;
  logic [50:0] num_q, den_q;
  logic [35:0] mag_q;
  logic        neg_q;
  logic [62:0] prod_q;
  logic [29:0] a_q, b_q;
  logic [46:0] c_q;
  logic [59:0] p_q;
  logic [61:0] cc_q;
  logic        big_q;

  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [95:0] div_num;
  logic [63:0] div_den, div_quo;
  logic [31:0] sqrt_root;
  logic        own_sat, corr_clip;

  logic [49:0] sum;
  logic [63:0] sq64;
  logic [32:0] t33;
  logic [29:0] frac_nx;
  logic [36:0] d37;
  logic [63:0] rsum;
  logic [4:0]  sa, sb, sa_fix, half;
  logic [5:0]  shsum;
  logic [48:0] a_full, b_full, a_sh, b_sh;
  logic [47:0] crs, cabs;

  function automatic logic [1:0] nonref(logic [1:0] j, logic [1:0] r);
    return (j < r) ? j : j + 2'd1;
  endfunction

  ovff_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ovff_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (div_quo),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    sum = 50'(job_q.che[0]) + 50'(job_q.che[1]) + 50'(job_q.che[2]) + 50'(job_q.che[3]);
    sq64    = 64'(m_q) * 64'(m_q);
    t33     = sq64[63:31];
    frac_nx = {frac_q[28:0], t33[32]};
    d37     = {1'b0, lg_q[idx_q]} - {1'b0, lg_ref_q};
    rsum    = {1'b0, prod_q} + RND_HALF;
    // even total shift so the cross term can take exactly half of it
    sa     = (ex_q[idx_q] >= EXP_KEEP) ? 5'(ex_q[idx_q] - EXP_KEEP) : 5'd0;
    sb     = (ex_ref_q >= EXP_KEEP) ? 5'(ex_ref_q - EXP_KEEP) : 5'd0;
    sa_fix = sa + {4'd0, sa[0] ^ sb[0]};
    shsum  = {1'b0, sa_fix} + {1'b0, sb};
    half   = shsum[5:1];
    a_full = {1'b0, job_q.che[idx_q]} + 49'd1;
    b_full = {1'b0, eref_q} + 49'd1;
    a_sh   = a_full >> sa_fix;
    b_sh   = b_full >> sb;
    crs    = job_q.crs[idx_q];
    cabs   = crs[47] ? (48'd0 - crs) : crs;
    own_sat   = ({30'd0, num_q} >= {den_q, 30'd0});
    corr_clip = big_q || (cc_q >= p_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:      if (!job_empty_i) state_d = job_i.bad ? B_EMIT : B_SUM;
      B_SUM:       state_d = B_OWN_CHK;
      B_OWN_CHK:   state_d = own_sat ? B_EMIT : B_OWN_DIV;
      B_OWN_DIV:   if (div_done) state_d = B_OWN_SQRT;
      B_OWN_SQRT:  if (sqrt_done) state_d = B_EMIT;
      B_LOAD:      state_d = B_NORM;
      B_NORM:      if (v_q[48]) state_d = B_LOG;
      B_LOG: begin
        if (it_q == LOG_LAST) state_d = (idx_q == CH_LAST) ? B_LVL : B_LOAD;
      end
      B_LVL:       state_d = B_LVL_MUL;
      B_LVL_MUL:   state_d = B_LVL_RND;
      B_LVL_RND:   state_d = B_EMIT;
      B_CORR:      state_d = B_CORR_MUL;
      B_CORR_MUL:  state_d = B_CORR_CMP;
      B_CORR_CMP:  state_d = corr_clip ? B_EMIT : B_CORR_DIV;
      B_CORR_DIV:  if (div_done) state_d = B_CORR_SQRT;
      B_CORR_SQRT: if (sqrt_done) state_d = B_EMIT;
      B_EMIT: begin
        if (!res_full_i) begin
          priority if (job_q.bad)          state_d = (feat_q == FEAT_LAST) ? B_IDLE : B_EMIT;
          else if (feat_q == FEAT_OWN)     state_d = B_LOAD;
          else if (feat_q < FEAT_CORR0)    state_d = (j_q == J_LAST) ? B_CORR : B_LVL;
          else                             state_d = (feat_q == FEAT_LAST) ? B_IDLE : B_CORR;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o  = (state_q == B_IDLE) && !job_empty_i;
    res_push_o = (state_q == B_EMIT) && !res_full_i;
    div_start  = ((state_q == B_OWN_CHK) && !own_sat) ||
                 ((state_q == B_CORR_CMP) && !corr_clip);
    sqrt_start = ((state_q == B_OWN_DIV) || (state_q == B_CORR_DIV)) && div_done;
    if (state_q == B_OWN_CHK) begin
      div_num = {13'd0, num_q, 32'd0};
      div_den = {13'd0, den_q};
    end else begin
      div_num = {2'd0, cc_q, 32'd0};
      div_den = {4'd0, p_q};
    end
  end

  assign res_o.feature_index = feat_q;
  assign res_o.feature_value = val_q;
  assign res_o.seq_out       = job_q.seq;
  assign res_o.time_out      = job_q.tstamp;
  assign res_o.obs_valid     = !job_q.bad;
  assign res_o.last_feature  = (feat_q == FEAT_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_q  <= job_i;
          eref_q <= job_i.che[job_i.ref_mic];
          val_q  <= 32'd0;
          feat_q <= FEAT_OWN;
        end
      end
      B_SUM: begin
        den_q <= 51'(sum) + 51'd4;
        num_q <= {({1'b0, job_q.own} + 49'd1), 2'b00};
      end
      B_OWN_CHK:  if (own_sat) val_q <= QMAX;
      B_OWN_DIV:  ;
      B_OWN_SQRT: if (sqrt_done) val_q <= {1'b0, sqrt_root[30:0]};
      B_LOAD: begin
        v_q <= a_full;
        e_q <= EXP_TOP;
      end
      B_NORM: begin
        if (v_q[48]) begin
          m_q    <= v_q[48:17];
          frac_q <= '0;
          it_q   <= 5'd0;
        end else begin
          v_q <= {v_q[47:0], 1'b0};
          e_q <= e_q - 6'd1;
        end
      end
      B_LOG: begin
        // mantissa squaring, one fraction bit per cycle
        m_q    <= t33[32] ? t33[32:1] : t33[31:0];
        frac_q <= frac_nx;
        it_q   <= it_q + 5'd1;
        if (it_q == LOG_LAST) begin
          lg_q[idx_q] <= {e_q, frac_nx};
          ex_q[idx_q] <= e_q;
          if (idx_q == job_q.ref_mic) begin
            lg_ref_q <= {e_q, frac_nx};
            ex_ref_q <= e_q;
          end
          j_q   <= 2'd0;
          idx_q <= (idx_q == CH_LAST) ? nonref(2'd0, job_q.ref_mic) : idx_q + 2'd1;
        end
      end
      B_LVL: begin
        neg_q <= d37[36];
        mag_q <= d37[36] ? 36'(37'd0 - d37) : d37[35:0];
      end
      B_LVL_MUL: prod_q <= 63'(mag_q) * 63'(HALF_LN2_Q28);
      B_LVL_RND: begin
        val_q  <= neg_q ? (32'd0 - {10'd0, rsum[63:42]}) : {10'd0, rsum[63:42]};
        feat_q <= FEAT_LVL0 + {1'b0, j_q};
      end
      B_CORR: begin
        a_q   <= (a_sh[29:0] == 30'd0) ? 30'd1 : a_sh[29:0];
        b_q   <= (b_sh[29:0] == 30'd0) ? 30'd1 : b_sh[29:0];
        c_q   <= cabs[46:0] >> half;
        neg_q <= crs[47];
      end
      B_CORR_MUL: begin
        p_q   <= 60'(a_q) * 60'(b_q);
        cc_q  <= 62'(c_q[30:0]) * 62'(c_q[30:0]);
        big_q <= |c_q[46:31];
      end
      B_CORR_CMP: begin
        feat_q <= FEAT_CORR0 + {1'b0, j_q};
        if (corr_clip) val_q <= neg_q ? (32'd0 - ONE_Q16) : ONE_Q16;
      end
      B_CORR_DIV: ;
      B_CORR_SQRT: begin
        if (sqrt_done) val_q <= neg_q ? (32'd0 - sqrt_root) : sqrt_root;
      end
      B_EMIT: begin
        if (!res_full_i) begin
          priority if (job_q.bad) begin
            feat_q <= feat_q + 3'd1;
          end else if (feat_q == FEAT_OWN) begin
            idx_q <= 2'd0;
          end else if (feat_q < FEAT_CORR0 && j_q == J_LAST) begin
            j_q   <= 2'd0;
            idx_q <= nonref(2'd0, job_q.ref_mic);
          end else begin
            j_q   <= j_q + 2'd1;
            idx_q <= nonref(j_q + 2'd1, job_q.ref_mic);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/own_voice_frame_features.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// config    in         cfg_we_i            cfg_wdata_i (reference mic)
// instant   in         push / full         item_i   (ovff_pkg::item_t)
// feature   out        empty / pop         result_o (ovff_pkg::result_t)
//
// an accepted instant holds full high through four channel multiply-accumulate
// steps and a hand-off, so a new instant is taken only once the last one is through
// at a frame end the back sequencer works out the seven features (a flagged frame
// emits them without working them out) with serial divides, square roots and a
// bit-serial log per channel; a two-word frame queue lets it overlap the next frame
// reset is asynchronous and clears all sums and the reference mic; a stalled result
// side backs up into the frame queue and then into full

module own_voice_frame_features (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  ovff_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output ovff_pkg::result_t result_o
);

  import ovff_pkg::*;

  job_t    job_wr, job_rd;
  result_t res_wr;
  logic    job_push, job_full, job_pop, job_empty;
  logic    res_push, res_full;
  logic [$bits(job_t)-1:0]    job_dout;
  logic [$bits(result_t)-1:0] res_dout;

  ovff_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .job_full_i  (job_full),
    .job_push_o  (job_push),
    .job_o       (job_wr)
  );

  ovff_fifo #(.WIDTH($bits(job_t))) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .din_i   (job_wr),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .dout_o  (job_dout),
    .empty_o (job_empty)
  );

  assign job_rd = job_t'(job_dout);

  ovff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_i       (job_rd),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wr)
  );

  ovff_fifo #(.WIDTH($bits(result_t))) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .din_i   (res_wr),
    .full_o  (res_full),
    .pop_i   (pop),
    .dout_o  (res_dout),
    .empty_o (empty)
  );

  assign result_o = result_t'(res_dout);

endmodule
